/* design/fhp_pkg.sv */
// ----------------------------------------------------------------------------
// fhp_pkg
// Shared types, constants and helper functions for the fire heat block.
// ----------------------------------------------------------------------------
package fhp_pkg;

   // Map geometry
   localparam int MAP_WIDTH  = 128;
   localparam int MAP_HEIGHT = 64;
   localparam int COL_W      = $clog2(MAP_WIDTH);
   localparam int ROW_W      = $clog2(MAP_HEIGHT);
   localparam int ADDR_W     = ROW_W + COL_W;
   localparam int DEPTH      = MAP_WIDTH * MAP_HEIGHT;

   // Heat constants
   localparam int HEAT_W       = 6;
   localparam int MAX_HEAT     = 63;
   localparam int GROUND_HEAT  = (MAX_HEAT * 2) / 3;
   localparam int SOFT_FLOOR   = 3;
   localparam int SOFT_SPAN    = 7 * 3 + 3;
   localparam int RATE_W       = 12;
   localparam logic [31:0] SEED_DEFAULT = 32'h2545F491;

   // Transaction opcodes
   localparam logic [1:0] OP_FRAME = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_DIGIT_TOP = 3'd0;
   localparam logic [2:0] REG_FLAME_H   = 3'd1;
   localparam logic [2:0] REG_GROUND_H  = 3'd2;
   localparam logic [2:0] REG_WIND      = 3'd3;
   localparam logic [2:0] REG_SMOOTH    = 3'd4;
   localparam logic [2:0] REG_SEED      = 3'd5;

   // Wind modes
   localparam logic [1:0] WIND_JITTER = 2'd1;
   localparam logic [1:0] WIND_RIGHT  = 2'd2;

   // Heat memory write request
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [HEAT_W-1:0] data;
   } ram_wr_type;

   // Advance the xorshift32 generator by one step
   function automatic logic [31:0] xorshift(input logic [31:0] s);
      logic [31:0] v;
      v = s ^ (s << 13);
      v = v ^ (v >> 17);
      v = v ^ (v << 5);
      return v;
   endfunction

   // Q4.8 plume cooling rate, floor(63*256/h), height clamped to 8..40
   function automatic logic [RATE_W-1:0] flame_rate(input logic [5:0] h);
      logic [RATE_W-1:0] q;
      priority if (h <= 6'd8) begin
         q = 12'd2016;
      end else if (h >= 6'd40) begin
         q = 12'd403;
      end else begin
         unique case (h)
            6'd9:  q = 12'd1792;
            6'd10: q = 12'd1612;
            6'd11: q = 12'd1466;
            6'd12: q = 12'd1344;
            6'd13: q = 12'd1240;
            6'd14: q = 12'd1152;
            6'd15: q = 12'd1075;
            6'd16: q = 12'd1008;
            6'd17: q = 12'd948;
            6'd18: q = 12'd896;
            6'd19: q = 12'd848;
            6'd20: q = 12'd806;
            6'd21: q = 12'd768;
            6'd22: q = 12'd733;
            6'd23: q = 12'd701;
            6'd24: q = 12'd672;
            6'd25: q = 12'd645;
            6'd26: q = 12'd620;
            6'd27: q = 12'd597;
            6'd28: q = 12'd576;
            6'd29: q = 12'd556;
            6'd30: q = 12'd537;
            6'd31: q = 12'd520;
            6'd32: q = 12'd504;
            6'd33: q = 12'd488;
            6'd34: q = 12'd474;
            6'd35: q = 12'd460;
            6'd36: q = 12'd448;
            6'd37: q = 12'd435;
            6'd38: q = 12'd424;
            default: q = 12'd413;
         endcase
      end
      return q;
   endfunction

   // Q4.8 ground cooling rate, floor(42*256/h), height clamped to 5..40
   function automatic logic [RATE_W-1:0] ground_rate(input logic [5:0] h);
      logic [RATE_W-1:0] q;
      priority if (h <= 6'd5) begin
         q = 12'd2150;
      end else if (h >= 6'd40) begin
         q = 12'd268;
      end else begin
         unique case (h)
            6'd6:  q = 12'd1792;
            6'd7:  q = 12'd1536;
            6'd8:  q = 12'd1344;
            6'd9:  q = 12'd1194;
            6'd10: q = 12'd1075;
            6'd11: q = 12'd977;
            6'd12: q = 12'd896;
            6'd13: q = 12'd827;
            6'd14: q = 12'd768;
            6'd15: q = 12'd716;
            6'd16: q = 12'd672;
            6'd17: q = 12'd632;
            6'd18: q = 12'd597;
            6'd19: q = 12'd565;
            6'd20: q = 12'd537;
            6'd21: q = 12'd512;
            6'd22: q = 12'd488;
            6'd23: q = 12'd467;
            6'd24: q = 12'd448;
            6'd25: q = 12'd430;
            6'd26: q = 12'd413;
            6'd27: q = 12'd398;
            6'd28: q = 12'd384;
            6'd29: q = 12'd370;
            6'd30: q = 12'd358;
            6'd31: q = 12'd346;
            6'd32: q = 12'd336;
            6'd33: q = 12'd325;
            6'd34: q = 12'd316;
            6'd35: q = 12'd307;
            6'd36: q = 12'd298;
            6'd37: q = 12'd290;
            6'd38: q = 12'd282;
            default: q = 12'd275;
         endcase
      end
      return q;
   endfunction

endpackage

/* design/fire_heat_propagation.sv */
// Response: a write or an unused opcode answers through ST_RESP after
//   acceptance, an in-map read through ST_RD_WAIT and then ST_RESP.
// Frame: spread row by row down to the ground, a blur pass for each smoothed
//   row and a write of the ground row; spread and blur read each cell in one
//   state and write it in another on the single-write heat memory. One transaction at a time.
// Reset: synchronous; a clearing pass writes zero to all 8192 cells, one a
//   cycle, with req_stall high until the pass ends. Registers load defaults.
// ----------------------------------------------------------------------------
// fire_heat_propagation
// Heat map fire effect: frame step, cell write and cell read transactions.
// ----------------------------------------------------------------------------
module fire_heat_propagation (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [5:0]  req_cell_row,
   input  logic [6:0]  req_cell_col,
   input  logic [5:0]  req_heat_in,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_heat_out,
   output logic [5:0]  rsp_top_row,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int ROW_W  = fhp_pkg::ROW_W;
   localparam int COL_W  = fhp_pkg::COL_W;
   localparam int ADDR_W = fhp_pkg::ADDR_W;
   localparam int HW     = fhp_pkg::HEAT_W;
   localparam int RW     = fhp_pkg::RATE_W;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SETUP, ST_SP_RD, ST_SP_WR, ST_BL_PRIME, ST_BL_LOAD,
      ST_BL_RD, ST_BL_WR, ST_ROW_END, ST_GROUND, ST_RD_WAIT, ST_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ROW_W:0]    y_ff, y_in;
   logic [COL_W:0]    x_ff, x_in;
   logic [31:0]       rng_ff, rng_in;
   logic [31:0]       r_ff, r_in;
   logic [ROW_W-1:0]  hot_ff, hot_in;
   logic [ROW_W-1:0]  ntop_ff, ntop_in;
   logic              found_ff, found_in;
   logic              any_ff, any_in;
   logic [RW-1:0]     dq_ff, dq_in, gq_ff, gq_in, sq_ff, sq_in;
   logic signed [ROW_W+2:0] slim_ff, slim_in;
   logic [HW-1:0]     l_ff, l_in, c_ff, c_in;
   logic [HW-1:0]     res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [HW-1:0]     rsp_heat_ff, rsp_heat_in;
   logic [5:0]        rsp_top_ff, rsp_top_in;

   // registers
   logic [5:0]        digit_top_ff, digit_top_in;
   logic [5:0]        flame_h_ff, flame_h_in;
   logic [5:0]        ground_h_ff, ground_h_in;
   logic [1:0]        wind_ff, wind_in;
   logic              smooth_ff, smooth_in;

   fhp_pkg::ram_wr_type wr;
   logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
   logic [HW-1:0]     rd_a_data, rd_b_data;

   fhp_heat_ram u_ram (
      .clock     (clock),
      .wr        (wr),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // per-row and per-cell terms
   logic [31:0]             r_next;
   logic [ROW_W:0]          dst;
   logic                    smooth_row, digit;
   logic [RW-1:0]           q;
   logic signed [3:0]       woff;
   logic signed [COL_W+2:0] sxs;
   logic [COL_W-1:0]        sx;
   logic signed [5:0]       decay;
   logic [HW:0]             cooled;
   logic [HW:0]             blend;
   logic [HW-1:0]           spread_v;
   logic [7:0]              blur_sum;
   logic [HW-1:0]           blur_v;
   logic [COL_W-1:0]        bl_next;
   logic                    in_map;
   logic [RW+1:0]           dq3;
   logic signed [ROW_W+2:0] lim_a, lim_b;
   logic [ROW_W:0]          top_start;
   logic                    last_x;

   assign r_next     = fhp_pkg::xorshift(rng_ff);
   assign dst        = y_ff - 1'b1;
   assign smooth_row = smooth_ff && ($signed({2'b00, dst}) <= slim_ff);
   assign digit      = dst < (ROW_W + 1)'(digit_top_ff);
   assign q          = smooth_row ? sq_ff : (digit ? dq_ff : gq_ff);
   assign last_x     = x_ff == (COL_W + 1)'(fhp_pkg::MAP_WIDTH - 1);
   assign in_map     = (int'(req_cell_row) < fhp_pkg::MAP_HEIGHT) &&
                       (int'(req_cell_col) < fhp_pkg::MAP_WIDTH);

   // wind offset from the fresh random word
   always_comb begin
      logic signed [3:0] up, dn, drift;
      up    = 4'(r_next[0]) + 4'(r_next[1]) + 4'(r_next[2]);
      dn    = 4'(r_next[3]) + 4'(r_next[4]) + 4'(r_next[5]);
      drift = 4'(r_next[16]);
      priority if (wind_ff == fhp_pkg::WIND_JITTER) begin
         woff = up - dn;
      end else if (wind_ff == fhp_pkg::WIND_RIGHT) begin
         woff = up - dn + drift;
      end else begin
         woff = up - dn - drift;
      end
      sxs = $signed({2'b00, x_ff}) - (COL_W + 3)'(woff);
      priority if (sxs < 0) begin
         sx = '0;
      end else if (sxs > (COL_W + 3)'(fhp_pkg::MAP_WIDTH - 1)) begin
         sx = COL_W'(fhp_pkg::MAP_WIDTH - 1);
      end else begin
         sx = sxs[COL_W-1:0];
      end
   end

   // cool the pulled cell and blend for smoothed rows
   always_comb begin
      logic [1:0] sp;
      sp    = r_ff[25:24];
      decay = 6'(q[RW-1:8]);
      if (r_ff[15:8] < q[7:0]) decay = decay + 6'sd1;
      if (sp == 2'd0) decay = decay - 6'sd1;
      else if (sp == 2'd3) decay = decay + 6'sd1;
      if (decay < 0) decay = '0;
      cooled = ({1'b0, rd_a_data} > 7'(decay)) ? ({1'b0, rd_a_data} - 7'(decay)) : '0;
      blend  = 7'((8'(cooled) + 8'(rd_b_data) + 8'd1) >> 1);
      spread_v = smooth_row ? blend[HW-1:0] : cooled[HW-1:0];
   end

   // 1-2-1 blur with floor
   always_comb begin
      blur_sum = 8'(l_ff) + {1'b0, c_ff, 1'b0} + 8'(rd_a_data);
      blur_v   = blur_sum[7:2];
      if (blur_v < HW'(fhp_pkg::SOFT_FLOOR)) blur_v = '0;
      bl_next  = last_x ? x_ff[COL_W-1:0] : x_ff[COL_W-1:0] + 1'b1;
   end

   // frame setup terms
   always_comb begin
      dq3   = (RW + 2)'(fhp_pkg::flame_rate(flame_h_ff)) * (RW + 2)'(3);
      lim_a = (ROW_W + 3)'(digit_top_ff) + (ROW_W + 3)'(fhp_pkg::SOFT_SPAN);
      lim_b = (ROW_W + 3)'(fhp_pkg::MAP_HEIGHT - 3) -
              (ROW_W + 3)'(fhp_pkg::ground_rate(ground_h_ff) == '0 ? 6'd0 :
                 (ground_h_ff < 6'd5 ? 6'd5 : (ground_h_ff > 6'd40 ? 6'd40 : ground_h_ff)));
      top_start = (hot_ff == '0) ? (ROW_W + 1)'(1) : {1'b0, hot_ff};
   end

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      y_in         = y_ff;
      x_in         = x_ff;
      rng_in       = rng_ff;
      r_in         = r_ff;
      hot_in       = hot_ff;
      ntop_in      = ntop_ff;
      found_in     = found_ff;
      any_in       = any_ff;
      dq_in        = dq_ff;
      gq_in        = gq_ff;
      sq_in        = sq_ff;
      slim_in      = slim_ff;
      l_in         = l_ff;
      c_in         = c_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_heat_in  = rsp_heat_ff;
      rsp_top_in   = rsp_top_ff;
      digit_top_in = digit_top_ff;
      flame_h_in   = flame_h_ff;
      ground_h_in  = ground_h_ff;
      wind_in      = wind_ff;
      smooth_in    = smooth_ff;
      wr           = '0;
      rd_a_addr    = '0;
      rd_b_addr    = '0;

      // drop a delivered response
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr.en   = 1'b1;
            wr.addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(fhp_pkg::DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               res_in   = '0;
               state_in = ST_RESP;
               unique case (req_opcode)
                  fhp_pkg::OP_FRAME: state_in = ST_SETUP;
                  fhp_pkg::OP_WRITE: begin
                     if (in_map) begin
                        wr.en   = 1'b1;
                        wr.addr = {ROW_W'(req_cell_row), COL_W'(req_cell_col)};
                        wr.data = req_heat_in;
                        if (req_heat_in != '0 && ROW_W'(req_cell_row) < hot_ff) begin
                           hot_in = ROW_W'(req_cell_row);
                        end
                     end
                  end
                  fhp_pkg::OP_READ: begin
                     if (in_map) begin
                        rd_a_addr = {ROW_W'(req_cell_row), COL_W'(req_cell_col)};
                        state_in  = ST_RD_WAIT;
                     end
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_RD_WAIT: begin
            res_in   = rd_a_data;
            state_in = ST_RESP;
         end
         ST_SETUP: begin
            dq_in    = fhp_pkg::flame_rate(flame_h_ff);
            gq_in    = fhp_pkg::ground_rate(ground_h_ff);
            sq_in    = RW'(dq3 >> 2);
            slim_in  = (lim_b < lim_a) ? lim_b : lim_a;
            y_in     = top_start;
            x_in     = '0;
            found_in = 1'b0;
            any_in   = 1'b0;
            ntop_in  = ROW_W'(fhp_pkg::MAP_HEIGHT - 1);
            state_in = ST_SP_RD;
         end
         ST_SP_RD: begin
            rng_in    = r_next;
            r_in      = r_next;
            rd_a_addr = {y_ff[ROW_W-1:0], sx};
            rd_b_addr = {dst[ROW_W-1:0], x_ff[COL_W-1:0]};
            state_in  = ST_SP_WR;
         end
         ST_SP_WR: begin
            wr.en   = 1'b1;
            wr.addr = {dst[ROW_W-1:0], x_ff[COL_W-1:0]};
            wr.data = spread_v;
            if (!smooth_row && spread_v != '0) any_in = 1'b1;
            if (last_x) begin
               x_in     = '0;
               state_in = smooth_row ? ST_BL_PRIME : ST_ROW_END;
            end else begin
               x_in     = x_ff + 1'b1;
               state_in = ST_SP_RD;
            end
         end
         ST_BL_PRIME: begin
            rd_a_addr = {dst[ROW_W-1:0], {COL_W{1'b0}}};
            state_in  = ST_BL_LOAD;
         end
         ST_BL_LOAD: begin
            l_in     = rd_a_data;
            c_in     = rd_a_data;
            state_in = ST_BL_RD;
         end
         ST_BL_RD: begin
            rd_a_addr = {dst[ROW_W-1:0], bl_next};
            state_in  = ST_BL_WR;
         end
         ST_BL_WR: begin
            wr.en   = 1'b1;
            wr.addr = {dst[ROW_W-1:0], x_ff[COL_W-1:0]};
            wr.data = blur_v;
            if (blur_v != '0) any_in = 1'b1;
            l_in = c_ff;
            c_in = rd_a_data;
            if (last_x) begin
               x_in     = '0;
               state_in = ST_ROW_END;
            end else begin
               x_in     = x_ff + 1'b1;
               state_in = ST_BL_RD;
            end
         end
         ST_ROW_END: begin
            if (!found_ff && any_ff) begin
               found_in = 1'b1;
               ntop_in  = dst[ROW_W-1:0];
            end
            any_in = 1'b0;
            x_in   = '0;
            if (y_ff == (ROW_W + 1)'(fhp_pkg::MAP_HEIGHT - 1)) begin
               state_in = ST_GROUND;
            end else begin
               y_in     = y_ff + 1'b1;
               state_in = ST_SP_RD;
            end
         end
         ST_GROUND: begin
            rng_in  = r_next;
            wr.en   = 1'b1;
            wr.addr = {ROW_W'(fhp_pkg::MAP_HEIGHT - 1), x_ff[COL_W-1:0]};
            wr.data = HW'(fhp_pkg::GROUND_HEAT) - HW'(r_next[2:0]);
            if (last_x) begin
               hot_in   = ntop_ff;
               res_in   = '0;
               state_in = ST_RESP;
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_heat_in  = res_ff;
               rsp_top_in   = 6'(hot_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // register writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fhp_pkg::REG_DIGIT_TOP: digit_top_in = csr_data[5:0];
            fhp_pkg::REG_FLAME_H:   flame_h_in   = csr_data[5:0];
            fhp_pkg::REG_GROUND_H:  ground_h_in  = csr_data[5:0];
            fhp_pkg::REG_WIND:      wind_in      = csr_data[1:0];
            fhp_pkg::REG_SMOOTH:    smooth_in    = csr_data[0];
            fhp_pkg::REG_SEED: begin
               rng_in = (csr_data != '0) ? csr_data : fhp_pkg::SEED_DEFAULT;
            end
            default: ;
         endcase
      end
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         y_ff         <= '0;
         x_ff         <= '0;
         rng_ff       <= fhp_pkg::SEED_DEFAULT;
         hot_ff       <= ROW_W'(fhp_pkg::MAP_HEIGHT - 1);
         found_ff     <= 1'b0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         digit_top_ff <= 6'd21;
         flame_h_ff   <= 6'd20;
         ground_h_ff  <= 6'd10;
         wind_ff      <= 2'd0;
         smooth_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         y_ff         <= y_in;
         x_ff         <= x_in;
         rng_ff       <= rng_in;
         hot_ff       <= hot_in;
         found_ff     <= found_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
         digit_top_ff <= digit_top_in;
         flame_h_ff   <= flame_h_in;
         ground_h_ff  <= ground_h_in;
         wind_ff      <= wind_in;
         smooth_ff    <= smooth_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      r_ff        <= r_in;
      ntop_ff     <= ntop_in;
      dq_ff       <= dq_in;
      gq_ff       <= gq_in;
      sq_ff       <= sq_in;
      slim_ff     <= slim_in;
      l_ff        <= l_in;
      c_ff        <= c_in;
      res_ff      <= res_in;
      rsp_heat_ff <= rsp_heat_in;
      rsp_top_ff  <= rsp_top_in;
   end

   assign req_stall    = state_ff != ST_IDLE;
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_heat_out = rsp_heat_ff;
   assign rsp_top_row  = rsp_top_ff;

   // an accepted transaction makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block not busy after accepting a transaction");

   // spread never writes outside the destination row
   a_spread_row: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SP_WR |-> wr.en && wr.addr[ADDR_W-1:COL_W] == dst[ROW_W-1:0])
      else $error("spread write to wrong row");

   // a frame row always sits below the top row
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SP_RD |-> y_ff != '0 && y_ff < (ROW_W + 1)'(fhp_pkg::MAP_HEIGHT))
      else $error("frame row out of range");

endmodule

/* design/fhp_heat_ram.sv */
// ----------------------------------------------------------------------------
// fhp_heat_ram
// Heat map storage: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module fhp_heat_ram (
   input  logic                                  clock,
   input  fhp_pkg::ram_wr_type                   wr,
   input  logic [fhp_pkg::ADDR_W-1:0]            rd_a_addr,
   input  logic [fhp_pkg::ADDR_W-1:0]            rd_b_addr,
   output logic [fhp_pkg::HEAT_W-1:0]            rd_a_data,
   output logic [fhp_pkg::HEAT_W-1:0]            rd_b_data
);

   logic [fhp_pkg::HEAT_W-1:0] mem [fhp_pkg::DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read ports, registered read data
   always_ff @(posedge clock) begin
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule
